FILE: src/mlpf_pkg.sv
// Shared constants, types and codes for the multilevel priority FIFO.
package mlpf_pkg;

    localparam int MAX_LEVELS   = 8;
    localparam int LEVEL_DEPTH  = 16;
    localparam int TASK_ID_BITS = 16;

    localparam int LVL_W    = $clog2(MAX_LEVELS);
    localparam int LVLCNT_W = $clog2(MAX_LEVELS + 1);
    localparam int PTR_W    = $clog2(LEVEL_DEPTH);
    localparam int FILL_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W   = LVL_W + PTR_W;
    localparam int STORE_DEPTH = MAX_LEVELS * (2 ** PTR_W);

    typedef logic [TASK_ID_BITS-1:0] task_t;
    typedef logic [LVL_W-1:0]        lvl_t;
    typedef logic [LVLCNT_W-1:0]     lvlcnt_t;
    typedef logic [PTR_W-1:0]        ptr_t;
    typedef logic [FILL_W-1:0]       fill_t;
    typedef logic [ADDR_W-1:0]       addr_t;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_BAD_PRIO  = 2'd1,
        ERR_FULL      = 2'd2,
        ERR_POP_EMPTY = 2'd3
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

FILE: src/multilevel_priority_fifo.sv
// Multilevel priority FIFO: per-level task rings in one shared task store.
// Flow: the accept edge captures the beat and issues the registered head read of the
// task store; in EXEC the item commits, loading the output register, once the output
// slot is free or draining. A new beat is taken only after the current one commits.
// Reset: rst_n is asynchronous, active low; clears pointers, fill counts and
// handshake state, and sets the level register to 8. The task store is not cleared.
module multilevel_priority_fifo (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  levels_in_use,

    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] task_id,
    input  logic [3:0]  priority_req,

    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        head_valid,
    output logic [15:0] head_task_id,
    output logic [3:0]  head_priority,
    output logic [7:0]  total_count,
    output logic [4:0]  level_count,
    output logic [1:0]  error_code
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    mlpf_pkg::state_t state_reg, state_next;

    logic [3:0]      levels_reg;

    mlpf_pkg::ptr_t  head_ptr_reg [mlpf_pkg::MAX_LEVELS];
    mlpf_pkg::ptr_t  tail_ptr_reg [mlpf_pkg::MAX_LEVELS];
    mlpf_pkg::fill_t fill_reg     [mlpf_pkg::MAX_LEVELS];
    mlpf_pkg::ptr_t  head_ptr_next[mlpf_pkg::MAX_LEVELS];
    mlpf_pkg::ptr_t  tail_ptr_next[mlpf_pkg::MAX_LEVELS];
    mlpf_pkg::fill_t fill_next    [mlpf_pkg::MAX_LEVELS];

    // captured input beat
    logic [1:0]      op_reg;
    mlpf_pkg::task_t tid_reg;
    logic [3:0]      pr_reg;

    // task store: one ring of LEVEL_DEPTH entries per level, addressed {level, ptr}
    mlpf_pkg::task_t task_store [mlpf_pkg::STORE_DEPTH];
    mlpf_pkg::task_t rd_data_reg;
    mlpf_pkg::addr_t rd_addr;
    mlpf_pkg::addr_t wr_addr;
    logic            wr_en;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        head_valid_reg;
    logic [15:0] head_task_id_reg;
    logic [3:0]  head_priority_reg;
    logic [7:0]  total_count_reg;
    logic [4:0]  level_count_reg;
    logic [1:0]  error_code_reg;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic              in_accept;
    logic              commit;
    mlpf_pkg::lvlcnt_t act_levels;
    logic              found_v;
    mlpf_pkg::lvl_t    found_idx;
    logic              pr_ok;
    mlpf_pkg::lvl_t    pr_idx;
    mlpf_pkg::err_t    err;
    logic [7:0]        total_sum;
    logic [4:0]        lcount;

    assign cfg_ready = 1'b1;            // the user must send config only while idle; the block does not enforce it
    assign in_stall  = (state_reg != mlpf_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // An item in EXEC finishes once the output slot is free or draining.
    assign commit = (state_reg == mlpf_pkg::ST_EXEC) && (!out_valid_reg || !out_stall);

    // Active level count, saturated to MAX_LEVELS.
    assign act_levels = (32'(levels_reg) > mlpf_pkg::MAX_LEVELS)
                        ? mlpf_pkg::LVLCNT_W'(mlpf_pkg::MAX_LEVELS)
                        : mlpf_pkg::LVLCNT_W'(levels_reg);

    // Highest non-empty active level. Pointers and fills only move on commit,
    // so this is the same at the accept edge and during EXEC.
    always_comb
    begin
        found_v   = 1'b0;
        found_idx = '0;
        for (int i = 0; i < mlpf_pkg::MAX_LEVELS; i++)
        begin
            if ((i < 32'(act_levels)) && (fill_reg[i] != '0))
            begin
                found_v   = 1'b1;
                found_idx = mlpf_pkg::LVL_W'(i);
            end
        end
    end

    // Head read is issued on the accept edge, data lands for EXEC.
    assign rd_addr = {found_idx, head_ptr_reg[found_idx]};

    assign pr_ok  = (pr_reg != 4'd0) && (32'(pr_reg) <= 32'(act_levels));
    assign pr_idx = mlpf_pkg::LVL_W'(pr_reg - 4'd1);

    function automatic mlpf_pkg::ptr_t ring_next(input mlpf_pkg::ptr_t p);
        ring_next = (p == mlpf_pkg::PTR_W'(mlpf_pkg::LEVEL_DEPTH - 1))
                    ? '0 : p + mlpf_pkg::PTR_W'(1);
    endfunction

    // Operation decode and state update
    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        fill_next     = fill_reg;
        err           = mlpf_pkg::ERR_OK;
        wr_en         = 1'b0;
        wr_addr       = {pr_idx, tail_ptr_reg[pr_idx]};

        case (op_reg)
            mlpf_pkg::OP_PUSH:
            begin
                if (!pr_ok)
                    err = mlpf_pkg::ERR_BAD_PRIO;
                else if (32'(fill_reg[pr_idx]) >= mlpf_pkg::LEVEL_DEPTH)
                    err = mlpf_pkg::ERR_FULL;
                else
                begin
                    wr_en                 = 1'b1;
                    tail_ptr_next[pr_idx] = ring_next(tail_ptr_reg[pr_idx]);
                    fill_next[pr_idx]     = fill_reg[pr_idx] + mlpf_pkg::FILL_W'(1);
                end
            end
            mlpf_pkg::OP_POP:
            begin
                if (!found_v)
                    err = mlpf_pkg::ERR_POP_EMPTY;
                else
                begin
                    head_ptr_next[found_idx] = ring_next(head_ptr_reg[found_idx]);
                    fill_next[found_idx]     = fill_reg[found_idx] - mlpf_pkg::FILL_W'(1);
                end
            end
            default:
            begin
                // query, and the unused opcode, only report
                if (!pr_ok)
                    err = mlpf_pkg::ERR_BAD_PRIO;
            end
        endcase
    end

    // Counts after the operation
    always_comb
    begin
        total_sum = '0;
        for (int i = 0; i < mlpf_pkg::MAX_LEVELS; i++)
        begin
            if (i < 32'(act_levels))
                total_sum = total_sum + 8'(fill_next[i]);
        end
        lcount = pr_ok ? 5'(fill_next[pr_idx]) : 5'd0;
    end

    // Next state and output slot control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlpf_pkg::ST_IDLE:
            begin
                if (in_accept)
                    state_next = mlpf_pkg::ST_EXEC;
            end
            mlpf_pkg::ST_EXEC:
            begin
                if (commit)
                    state_next = mlpf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mlpf_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = commit ? 1'b1 : (out_valid_reg && out_stall);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlpf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            levels_reg    <= 4'd8;
            for (int i = 0; i < mlpf_pkg::MAX_LEVELS; i++)
            begin
                head_ptr_reg[i] <= '0;
                tail_ptr_reg[i] <= '0;
                fill_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                levels_reg <= levels_in_use;
            if (commit)
            begin
                head_ptr_reg <= head_ptr_next;
                tail_ptr_reg <= tail_ptr_next;
                fill_reg     <= fill_next;
            end
        end
    end

    // Captured beat and result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= opcode;
            tid_reg <= mlpf_pkg::task_t'(task_id);
            pr_reg  <= priority_req;
        end
        if (commit)
        begin
            head_valid_reg    <= found_v;
            head_task_id_reg  <= found_v ? 16'(rd_data_reg) : 16'd0;
            head_priority_reg <= found_v ? (4'(found_idx) + 4'd1) : 4'd0;
            total_count_reg   <= total_sum;
            level_count_reg   <= lcount;
            error_code_reg    <= err;
        end
    end

    // Task store: one write port (push), one registered read port (head)
    always_ff @(posedge clk)
    begin
        if (commit && wr_en)
            task_store[wr_addr] <= tid_reg;
        if (in_accept)
            rd_data_reg <= task_store[rd_addr];
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid     = out_valid_reg;
    assign head_valid    = head_valid_reg;
    assign head_task_id  = head_task_id_reg;
    assign head_priority = head_priority_reg;
    assign total_count   = total_count_reg;
    assign level_count   = level_count_reg;
    assign error_code    = error_code_reg;

endmodule

FILE: dv/mlpf_checker.sv
// Checker for the multilevel priority FIFO: tracks the level rings and compares every report.
module mlpf_checker
    import mlpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  levels_in_use,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] task_id,
    input  logic [3:0]  priority_req,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        head_valid,
    input  logic [15:0] head_task_id,
    input  logic [3:0]  head_priority,
    input  logic [7:0]  total_count,
    input  logic [4:0]  level_count,
    input  logic [1:0]  error_code,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        head_valid;
        task_t       head_task_id;
        logic [3:0]  head_priority;
        logic [7:0]  total_count;
        logic [4:0]  level_count;
        err_t        error_code;
    } queue_report_t;

    // model copy of the per-level rings
    task_t       ring_mem  [MAX_LEVELS][LEVEL_DEPTH];
    int unsigned ring_rd   [MAX_LEVELS];
    int unsigned ring_wr   [MAX_LEVELS];
    int unsigned ring_fill [MAX_LEVELS];
    logic [3:0]  levels_cfg;

    queue_report_t pending_reports[$];
    int            mismatches;

    function automatic int unsigned ring_step(input int unsigned p);
        return (p + 1 >= LEVEL_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic queue_report_t predict_queue_op(input logic [1:0] op, input task_t tid,
                                                       input logic [3:0] prio);
        queue_report_t rep;
        int            active;
        int            top_lvl;
        int            total;
        int            lvl;
        bit            prio_ok;
        active  = (levels_cfg > MAX_LEVELS) ? MAX_LEVELS : int'(levels_cfg);
        top_lvl = -1;
        for (int i = active - 1; i >= 0; i--)
            if (top_lvl < 0 && ring_fill[i] != 0)
                top_lvl = i;
        prio_ok = (prio >= 1) && (int'(prio) <= active);

        // head as it stood before the operation
        rep.head_valid    = (top_lvl >= 0);
        rep.head_task_id  = '0;
        rep.head_priority = 4'd0;
        if (top_lvl >= 0)
        begin
            rep.head_task_id  = ring_mem[top_lvl][ring_rd[top_lvl]];
            rep.head_priority = 4'(top_lvl + 1);
        end
        rep.error_code = ERR_OK;

        if (op == OP_PUSH)
        begin
            if (!prio_ok)
                rep.error_code = ERR_BAD_PRIO;
            else
            begin
                lvl = int'(prio) - 1;
                if (ring_fill[lvl] >= LEVEL_DEPTH)
                    rep.error_code = ERR_FULL;
                else
                begin
                    ring_mem[lvl][ring_wr[lvl]] = tid;
                    ring_wr[lvl]   = ring_step(ring_wr[lvl]);
                    ring_fill[lvl] = ring_fill[lvl] + 1;
                end
            end
        end
        else if (op == OP_POP)
        begin
            if (top_lvl < 0)
                rep.error_code = ERR_POP_EMPTY;
            else
            begin
                ring_rd[top_lvl]   = ring_step(ring_rd[top_lvl]);
                ring_fill[top_lvl] = ring_fill[top_lvl] - 1;
            end
        end
        else if (!prio_ok)
            rep.error_code = ERR_BAD_PRIO;   // query, and opcode three acts as one

        // counts taken after the operation
        total = 0;
        for (int i = 0; i < active; i++)
            total += ring_fill[i];
        rep.total_count = 8'(total);
        rep.level_count = 5'd0;
        if (prio_ok)
            rep.level_count = 5'(ring_fill[int'(prio) - 1]);
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                ring_rd[i]   = 0;
                ring_wr[i]   = 0;
                ring_fill[i] = 0;
            end
            levels_cfg = 4'd8;
            pending_reports.delete();
            mismatches  = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result beat: compare against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: report beat with nothing pending", $realtime);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (head_valid !== want.head_valid || head_task_id !== want.head_task_id ||
                        head_priority !== want.head_priority ||
                        total_count !== want.total_count ||
                        level_count !== want.level_count || error_code !== want.error_code)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch exp hv=%0d id=%h pr=%0d tot=%0d lc=%0d err=%0d",
                                     $realtime, want.head_valid, want.head_task_id,
                                     want.head_priority, want.total_count, want.level_count,
                                     want.error_code);
                            $display("%0t:          got hv=%0d id=%h pr=%0d tot=%0d lc=%0d err=%0d",
                                     $realtime, head_valid, head_task_id, head_priority,
                                     total_count, level_count, error_code);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                levels_cfg = levels_in_use;
            if (in_valid && !in_stall)
                pending_reports.push_back(predict_queue_op(opcode, task_id, priority_req));
            fail_count  <= mismatches;
            outstanding <= pending_reports.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the multilevel priority FIFO testbench: clock, reset, stimulus and verdict.
module testbench;
    import mlpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // opcode three is not in the package enum; the block treats it as a query
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int         LONG_HOLD   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  levels_in_use = 4'd8;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = OP_PUSH;
    logic [15:0] task_id = '0;
    logic [3:0]  priority_req = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        head_valid;
    logic [15:0] head_task_id;
    logic [3:0]  head_priority;
    logic [7:0]  total_count;
    logic [4:0]  level_count;
    logic [1:0]  error_code;

    int          fail_count;
    int          outstanding;

    // sender / receiver pacing
    int          idle_pct  = 29;
    int          stall_pct = 29;
    bit          hold_req  = 1'b0;
    int          hold_left = 0;
    int          cur_levels = 8;

    always #1 clk = ~clk;

    multilevel_priority_fifo uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .levels_in_use (levels_in_use),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .task_id       (task_id),
        .priority_req  (priority_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .head_valid    (head_valid),
        .head_task_id  (head_task_id),
        .head_priority (head_priority),
        .total_count   (total_count),
        .level_count   (level_count),
        .error_code    (error_code)
    );

    mlpf_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .levels_in_use (levels_in_use),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .task_id       (task_id),
        .priority_req  (priority_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .head_valid    (head_valid),
        .head_task_id  (head_task_id),
        .head_priority (head_priority),
        .total_count   (total_count),
        .level_count   (level_count),
        .error_code    (error_code),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Receiver: random stall, or one long hold-off when the stimulus asks for it.
    // The hold is counted here so the sender keeps pushing beats into a blocked block.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one beat, with random idle cycles ahead of it; returns on the accept edge
    // with in_valid still high so back-to-back beats never drop valid.
    task automatic send_op(input logic [1:0] op, input logic [15:0] tid, input logic [3:0] prio);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        task_id      <= tid;
        priority_req <= prio;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Sender goes quiet until every predicted report has been seen.
    // The first edge lets the checker's count catch up with the last accepted beat.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Register write; only called with the block drained.
    task automatic write_levels(input logic [3:0] value);
        cfg_valid     <= 1'b1;
        levels_in_use <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        cur_levels = value;
    endtask

    // Mostly legal pushes/pops/queries with random ids; a slice of bad priorities and
    // opcode three as noise. push_w/pop_w steer whether levels fill up or drain.
    task automatic random_ops(input int count, input int push_w, input int pop_w,
                              input bit mid_pause);
        logic [1:0]  op;
        logic [3:0]  prio;
        int          pick;
        int          active;
        active = (cur_levels > MAX_LEVELS) ? MAX_LEVELS : cur_levels;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < push_w)
                op = OP_PUSH;
            else if (pick < push_w + pop_w)
                op = OP_POP;
            else if (pick < 95)
                op = OP_QUERY;
            else
                op = OP_RESERVED;
            if (active > 0 && $urandom_range(99) < 85)
                prio = 4'($urandom_range(active, 1));
            else
                prio = 4'($urandom_range(15));
            send_op(op, 16'($urandom), prio);
            if (mid_pause && n == count / 2)
                wait_drained();
        end
    endtask

    // Timeout guard
    initial
    begin
        #500us;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset setting of eight levels.
        send_op(OP_POP, 16'h0000, 4'd1);          // pop with nothing held
        send_op(OP_QUERY, 16'h0000, 4'd0);        // query below range
        send_op(OP_QUERY, 16'h0000, 4'd9);        // query above range
        send_op(OP_PUSH, 16'h1234, 4'd0);         // push below range, dropped
        send_op(OP_PUSH, 16'h4321, 4'd15);        // push far above range
        send_op(OP_PUSH, 16'hFFFF, 4'd8);         // top level, all-ones id
        send_op(OP_PUSH, 16'h0000, 4'd1);         // bottom level, zero id
        send_op(OP_RESERVED, 16'hAAAA, 4'd8);     // opcode three reads like a query
        send_op(OP_QUERY, 16'h5555, 4'd1);
        send_op(OP_POP, 16'h0000, 4'd8);          // removes the level-8 head
        send_op(OP_POP, 16'h0000, 4'd1);          // then the level-1 one
        send_op(OP_POP, 16'h0000, 4'd1);          // empty again
        for (int i = 0; i < LEVEL_DEPTH + 1; i++)
            send_op(OP_PUSH, 16'(16'h2000 + i), 4'd2);   // last one hits a full level

        // Random phases, each under its own register setting. The rings carry over,
        // so lowering the setting hides upper levels and raising it brings them back.
        wait_drained();
        write_levels(4'd8);
        random_ops(200, 50, 30, 1'b0);

        wait_drained();
        write_levels(4'd1);                        // one level, fills quickly
        random_ops(150, 60, 20, 1'b1);

        wait_drained();
        write_levels(4'd0);                        // no active level at all
        random_ops(40, 45, 35, 1'b0);

        wait_drained();
        write_levels(4'd15);                       // above range, acts as eight
        random_ops(200, 45, 35, 1'b1);

        // long stretch with no idling on either side
        wait_drained();
        write_levels(4'd3);
        idle_pct  = 0;
        stall_pct <= 0;
        random_ops(200, 40, 40, 1'b0);

        // receiver holds off while the sender streams, so the block backs up
        wait_drained();
        write_levels(4'd9);
        stall_pct <= 29;
        hold_req  <= 1'b1;
        @(posedge clk);
        hold_req  <= 1'b0;
        random_ops(150, 50, 30, 1'b0);
        idle_pct = 29;

        wait_drained();
        write_levels(4'd5);
        random_ops(200, 35, 45, 1'b1);

        wait_drained();
        write_levels(4'd2);
        random_ops(200, 55, 30, 1'b0);

        wait_drained();
        write_levels(4'd8);                        // mostly pops to drain deep state
        random_ops(250, 30, 55, 1'b1);

        wait_drained();
        write_levels(4'd6);
        random_ops(200, 45, 35, 1'b0);

        // drain, then a few quiet cycles for any stray report beat
        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
